@@ rtl/iss_pkg.sv @@
// Shared constants, codes and types for the indexed stack store.
`timescale 1ns / 1ps
package iss_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int ELEM_W_DEF = 32;

    localparam int MODE_W  = 3;
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_O_W = 9;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_mode MODE_PUSH  = 3'd0;
    localparam t_mode MODE_POP   = 3'd1;
    localparam t_mode MODE_GET   = 3'd2;
    localparam t_mode MODE_SET   = 3'd3;
    localparam t_mode MODE_TOP   = 3'd4;
    localparam t_mode MODE_CLEAR = 3'd5;
    localparam t_mode MODE_REV   = 3'd6;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    // Operation select for the shared adder: a + (b ^ inv) + cin
    typedef struct packed {
        logic inv_b;
        logic cin;
    } t_au_ctl;

    localparam t_au_ctl AU_ADD = '{inv_b: 1'b0, cin: 1'b0};
    localparam t_au_ctl AU_SUB = '{inv_b: 1'b1, cin: 1'b1};

endpackage

@@ rtl/iss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/iss_au.sv @@
// Shared add/subtract unit; carry out doubles as the a >= b flag on subtract.
`timescale 1ns / 1ps
module iss_au #(
    parameter int W = 9
) (
    input  logic             [W-1:0] i_a,
    input  logic             [W-1:0] i_b,
    input  iss_pkg::t_au_ctl         i_ctl,
    output logic             [W-1:0] o_sum,
    output logic                     o_carry
);
    import iss_pkg::*;

    logic [W:0] sum_full;

    always_comb begin
        sum_full = {1'b0, i_a} + {1'b0, i_b ^ {W{i_ctl.inv_b}}} + (W+1)'(i_ctl.cin);
    end

    assign o_sum   = sum_full[W-1:0];
    assign o_carry = sum_full[W];

endmodule

@@ rtl/indexed_stack_store.sv @@
// Top level: command sequencer, fill count and element memory of the stack store.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_mode, i_index, i_value
//   out     | output    | o_out_valid / i_out_ready  | o_read_data, o_status, o_count,
//           |           |                            | o_is_empty
//
// Pop, clear, set and flagged commands finish in the execute step; push writes, then
// raises the count; get and top read the entry; reverse swaps entry pairs from both
// ends inward. The sequencer passes through idle before the next accept. The single
// memory read/write port pair and the one shared adder set these steps.
// Reset clears the fill count and the sequencer; memory contents are left as they are.
// A result waiting on the output does not block the next command; a finished command
// holds in its last step until the output register is free.
`timescale 1ns / 1ps
module indexed_stack_store #(
    parameter int DEPTH      = iss_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = iss_pkg::ELEM_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  iss_pkg::t_mode                i_mode,
    input  logic [iss_pkg::IDX_W-1:0]     i_index,
    input  logic [iss_pkg::VAL_W-1:0]     i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [iss_pkg::VAL_W-1:0]     o_read_data,
    output iss_pkg::t_status              o_status,
    output logic [iss_pkg::CNT_O_W-1:0]   o_count,
    output logic                          o_is_empty
);
    import iss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int UW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_INC  = 4'd2;
    localparam logic [3:0] S_RDW  = 4'd3;
    localparam logic [3:0] S_RCHK = 4'd4;
    localparam logic [3:0] S_RRHI = 4'd5;
    localparam logic [3:0] S_WLO  = 4'd6;
    localparam logic [3:0] S_WHI  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_mode                 r_mode, n_mode;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [VAL_W-1:0]      r_val, n_val;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [ELEM_WIDTH-1:0] r_tmp, n_tmp;
    logic [VAL_W-1:0]      r_rdata, n_rdata;
    t_status               r_stat, n_stat;

    logic                  r_out_valid, n_out_valid;
    logic [VAL_W-1:0]      r_out_data, n_out_data;
    t_status               r_out_stat, n_out_stat;
    logic [CNT_O_W-1:0]    r_out_cnt, n_out_cnt;
    logic                  r_out_empty, n_out_empty;

    logic [UW-1:0]         au_a, au_b, au_sum;
    t_au_ctl               au_ctl;
    logic                  au_carry;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [UW-1:0]         cnt_ext, idx_ext;

    assign cnt_ext = UW'(r_count);
    assign idx_ext = UW'(r_idx);

    iss_au #(
        .W (UW)
    ) u_au (
        .i_a     (au_a),
        .i_b     (au_b),
        .i_ctl   (au_ctl),
        .o_sum   (au_sum),
        .o_carry (au_carry)
    );

    iss_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_tmp       = r_tmp;
        n_rdata     = r_rdata;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;
        n_out_empty = r_out_empty;

        au_a      = cnt_ext;
        au_b      = UW'(1);
        au_ctl    = AU_SUB;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = ELEM_WIDTH'(r_val);
        ram_raddr = r_lo;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_idx   = i_index;
                    n_val   = i_value;
                    n_rdata = '0;
                    n_stat  = ST_OK;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_mode)
                    MODE_PUSH: begin
                        au_b = UW'(DEPTH);
                        if (au_carry) begin
                            n_stat = ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_state = S_INC;
                        end
                    end
                    MODE_POP: begin
                        if (au_carry) begin
                            n_count = au_sum[CW-1:0];
                        end
                    end
                    MODE_GET: begin
                        au_a      = idx_ext;
                        au_b      = cnt_ext;
                        ram_raddr = idx_ext[AW-1:0];
                        if (au_carry) begin
                            n_stat = ST_RANGE;
                        end else begin
                            n_state = S_RDW;
                        end
                    end
                    MODE_SET: begin
                        au_a      = idx_ext;
                        au_b      = cnt_ext;
                        ram_waddr = idx_ext[AW-1:0];
                        if (au_carry) begin
                            n_stat = ST_RANGE;
                        end else begin
                            ram_we = 1'b1;
                        end
                    end
                    MODE_TOP: begin
                        ram_raddr = au_sum[AW-1:0];
                        if (!au_carry) begin
                            n_stat = ST_EMPTY;
                        end else begin
                            n_state = S_RDW;
                        end
                    end
                    MODE_CLEAR: begin
                        n_count = '0;
                    end
                    MODE_REV: begin
                        // count - 1 gives the upper end; empty store ends here
                        if (au_carry) begin
                            n_hi    = au_sum[AW-1:0];
                            n_lo    = '0;
                            n_state = S_RCHK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INC: begin
                au_ctl  = AU_ADD;
                n_count = au_sum[CW-1:0];
                n_state = S_DONE;
            end
            S_RDW: begin
                n_rdata = VAL_W'(ram_rdata);
                n_state = S_DONE;
            end
            S_RCHK: begin
                au_a      = UW'(r_lo);
                au_b      = UW'(r_hi);
                ram_raddr = r_lo;
                n_state   = au_carry ? S_DONE : S_RRHI;
            end
            S_RRHI: begin
                // lower entry arrives now, upper one next cycle
                ram_raddr = r_hi;
                n_tmp     = ram_rdata;
                n_state   = S_WLO;
            end
            S_WLO: begin
                au_a      = UW'(r_lo);
                au_ctl    = AU_ADD;
                ram_we    = 1'b1;
                ram_waddr = r_lo;
                ram_wdata = ram_rdata;
                n_lo      = au_sum[AW-1:0];
                n_state   = S_WHI;
            end
            S_WHI: begin
                au_a      = UW'(r_hi);
                ram_we    = 1'b1;
                ram_waddr = r_hi;
                ram_wdata = r_tmp;
                n_hi      = au_sum[AW-1:0];
                n_state   = S_RCHK;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rdata;
                    n_out_stat  = r_stat;
                    n_out_cnt   = CNT_O_W'(r_count);
                    n_out_empty = (r_count == '0);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_idx       <= n_idx;
        r_val       <= n_val;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_tmp       <= n_tmp;
        r_rdata     <= n_rdata;
        r_stat      <= n_stat;
        r_out_data  <= n_out_data;
        r_out_stat  <= n_out_stat;
        r_out_cnt   <= n_out_cnt;
        r_out_empty <= n_out_empty;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_stat;
    assign o_count     = r_out_cnt;
    assign o_is_empty  = r_out_empty;

endmodule
